// ===== design/crh_pkg.sv =====
// ----------------------------------------------------------------------------
// crh_pkg: shared types and constants for the Content-Range parser
// Request and result payloads, byte classes and the queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package crh_pkg;

  localparam int NUM_WIDTH   = 63;
  localparam int UNIT_WIDTH  = 8;
  localparam int QUEUE_DEPTH = 2;

  // byte classes handed from the front to the back
  localparam int CLS_WIDTH = 3;
  localparam logic [CLS_WIDTH-1:0] CLS_BLANK = 3'd0;
  localparam logic [CLS_WIDTH-1:0] CLS_DIGIT = 3'd1;
  localparam logic [CLS_WIDTH-1:0] CLS_TOKEN = 3'd2;  // token char, not digit/star/dash
  localparam logic [CLS_WIDTH-1:0] CLS_STAR  = 3'd3;
  localparam logic [CLS_WIDTH-1:0] CLS_DASH  = 3'd4;
  localparam logic [CLS_WIDTH-1:0] CLS_SLASH = 3'd5;
  localparam logic [CLS_WIDTH-1:0] CLS_OTHER = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 valid_res;
    logic                 has_range;
    logic [NUM_WIDTH-1:0] range_from;
    logic [NUM_WIDTH-1:0] range_to;
    logic                 has_length;
    logic [NUM_WIDTH-1:0] total_length;
    logic [UNIT_WIDTH-1:0] unit_length;
  } out_item_t;

  typedef struct packed {
    logic [CLS_WIDTH-1:0] cls;
    logic [3:0]           digit;
    logic                 last;
  } q_item_t;

endpackage

`default_nettype wire

// ===== design/crh_front.sv =====
// ----------------------------------------------------------------------------
// crh_front: request intake and byte classification
// Sorts each byte into a class and digit value and pushes it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module crh_front (
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire crh_pkg::in_item_t item,
  input  wire logic              q_full,
  output logic                   q_push,
  output crh_pkg::q_item_t       q_wdata
);
  import crh_pkg::*;

  logic [7:0] c;
  logic       is_alpha;

  assign c        = item.data_byte;
  assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);

  always_comb begin
    q_wdata.last  = item.last_byte;
    q_wdata.digit = c[3:0];
    if (c == 8'h20 || c == 8'h09) begin
      q_wdata.cls = CLS_BLANK;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      q_wdata.cls = CLS_DIGIT;
    end else if (c == 8'h2A) begin
      q_wdata.cls = CLS_STAR;
    end else if (c == 8'h2D) begin
      q_wdata.cls = CLS_DASH;
    end else if (c == 8'h2F) begin
      q_wdata.cls = CLS_SLASH;
    end else if (is_alpha || c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 ||
                 c == 8'h26 || c == 8'h27 || c == 8'h2B || c == 8'h2E || c == 8'h5E ||
                 c == 8'h5F || c == 8'h60 || c == 8'h7C || c == 8'h7E) begin
      q_wdata.cls = CLS_TOKEN;
    end else begin
      q_wdata.cls = CLS_OTHER;
    end
  end

  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

endmodule

`default_nettype wire

// ===== design/crh_queue.sv =====
// ----------------------------------------------------------------------------
// crh_queue: short queue between front and back
// Small FIFO of classified bytes; full is decoded from the registered count
// alone, so the front never waits on the back combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module crh_queue #(
  parameter int DEPTH = crh_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire crh_pkg::q_item_t wdata,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output crh_pkg::q_item_t      rdata
);
  import crh_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/crh_back.sv =====
// ----------------------------------------------------------------------------
// crh_back: grammar tracking, number accumulation and verdict
// Runs the phase machine one byte per cycle unless a last byte waits,
// snapshots its fields, checks them in a verdict stage, holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module crh_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  wire crh_pkg::q_item_t q_item,
  output logic                  q_pop,
  output logic                  res_valid,
  input  wire logic             res_stall,
  output crh_pkg::out_item_t    res
);
  import crh_pkg::*;

  localparam logic [2:0] PH_LEAD = 3'd0;
  localparam logic [2:0] PH_UNIT = 3'd1;
  localparam logic [2:0] PH_FROM = 3'd2;
  localparam logic [2:0] PH_TO   = 3'd3;
  localparam logic [2:0] PH_LEN  = 3'd4;

  localparam int MW = NUM_WIDTH + 4;

  // parser state
  logic [2:0]            phase,  phase_next;
  logic                  err,    err_next;
  logic [UNIT_WIDTH-1:0] unit,   unit_next;
  logic [NUM_WIDTH-1:0]  acc,    acc_next;
  logic                  ovf,    ovf_next;
  logic [NUM_WIDTH-1:0]  first,  first_next;
  logic [NUM_WIDTH-1:0]  second, second_next;
  logic                  rng,    rng_next;
  logic                  cont,   cont_next;
  logic                  closed, closed_next;
  logic                  star,   star_next;

  // verdict stage
  logic                  v_valid;
  logic                  v_ok, v_star, v_done, v_range;
  logic [NUM_WIDTH-1:0]  v_first, v_second, v_acc;
  logic [UNIT_WIDTH-1:0] v_unit;

  logic                  v_adv;
  logic                  v_free;
  logic [MW-1:0]         mac;
  logic                  done;
  logic                  is_token;
  logic                  fin_ok;
  logic                  len_given;
  logic                  keep_range;
  out_item_t             res_next;

  assign v_adv  = v_valid && (!res_valid || !res_stall);
  assign v_free = !v_valid || v_adv;
  assign q_pop  = q_valid && (!q_item.last || v_free);

  assign done     = cont && !ovf;
  assign is_token = (q_item.cls == CLS_DIGIT) || (q_item.cls == CLS_TOKEN) ||
                    (q_item.cls == CLS_STAR)  || (q_item.cls == CLS_DASH);
  // acc * 10 + digit
  assign mac = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + MW'(q_item.digit);

  always_comb begin
    phase_next  = phase;
    err_next    = err;
    unit_next   = unit;
    acc_next    = acc;
    ovf_next    = ovf;
    first_next  = first;
    second_next = second;
    rng_next    = rng;
    cont_next   = cont;
    closed_next = closed;
    star_next   = star;
    if (!err) begin
      unique case (phase) inside
        PH_LEAD: begin
          if (q_item.cls == CLS_BLANK) begin
            phase_next = PH_LEAD;
          end else if (is_token) begin
            unit_next  = UNIT_WIDTH'(1);
            phase_next = PH_UNIT;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_UNIT: begin
          if (is_token) begin
            if (unit != '1) unit_next = unit + 1'b1;
          end else if (q_item.cls == CLS_BLANK) begin
            phase_next  = PH_FROM;
            acc_next    = '0;
            ovf_next    = 1'b0;
            cont_next   = 1'b0;
            closed_next = 1'b0;
            star_next   = 1'b0;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_FROM, PH_TO, PH_LEN: begin
          if (q_item.cls == CLS_BLANK) begin
            if (cont || star) closed_next = 1'b1;
          end else if (q_item.cls == CLS_DIGIT) begin
            if (closed || star) begin
              err_next = 1'b1;
            end else begin
              if (mac[MW-1:NUM_WIDTH] != '0) ovf_next = 1'b1;
              else                           acc_next = mac[NUM_WIDTH-1:0];
              cont_next = 1'b1;
            end
          end else if (q_item.cls == CLS_STAR) begin
            if (phase != PH_TO && !cont && !star) star_next = 1'b1;
            else                                  err_next  = 1'b1;
          end else if (q_item.cls == CLS_DASH && phase == PH_FROM && done) begin
            first_next  = acc;
            phase_next  = PH_TO;
            acc_next    = '0;
            ovf_next    = 1'b0;
            cont_next   = 1'b0;
            closed_next = 1'b0;
            star_next   = 1'b0;
          end else if (q_item.cls == CLS_SLASH && phase == PH_FROM && star) begin
            rng_next    = 1'b0;
            phase_next  = PH_LEN;
            acc_next    = '0;
            ovf_next    = 1'b0;
            cont_next   = 1'b0;
            closed_next = 1'b0;
            star_next   = 1'b0;
          end else if (q_item.cls == CLS_SLASH && phase == PH_TO && done) begin
            second_next = acc;
            rng_next    = 1'b1;
            phase_next  = PH_LEN;
            acc_next    = '0;
            ovf_next    = 1'b0;
            cont_next   = 1'b0;
            closed_next = 1'b0;
            star_next   = 1'b0;
          end else begin
            err_next = 1'b1;
          end
        end
        default: begin
          err_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEAD;
      err    <= 1'b0;
      unit   <= '0;
      acc    <= '0;
      ovf    <= 1'b0;
      rng    <= 1'b0;
      cont   <= 1'b0;
      closed <= 1'b0;
      star   <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        // verdict taken; start over on the next request
        phase  <= PH_LEAD;
        err    <= 1'b0;
        unit   <= '0;
        acc    <= '0;
        ovf    <= 1'b0;
        rng    <= 1'b0;
        cont   <= 1'b0;
        closed <= 1'b0;
        star   <= 1'b0;
      end else begin
        phase  <= phase_next;
        err    <= err_next;
        unit   <= unit_next;
        acc    <= acc_next;
        ovf    <= ovf_next;
        rng    <= rng_next;
        cont   <= cont_next;
        closed <= closed_next;
        star   <= star_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      first  <= first_next;
      second <= second_next;
    end
  end

  // snapshot of the finished value
  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      v_valid <= 1'b1;
    end else if (v_adv) begin
      v_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      v_ok     <= !err_next && (phase_next == PH_LEN);
      v_star   <= star_next;
      v_done   <= cont_next && !ovf_next;
      v_range  <= rng_next;
      v_first  <= first_next;
      v_second <= second_next;
      v_acc    <= acc_next;
      v_unit   <= unit_next;
    end
  end

  assign len_given  = !v_star && v_done;
  assign fin_ok     = v_ok && (v_star || v_done) &&
                      !(v_range && (v_first > v_second)) &&
                      !(v_range && len_given && (v_second >= v_acc));
  assign keep_range = fin_ok && v_range;

  always_comb begin
    res_next.valid_res    = fin_ok;
    res_next.has_range    = keep_range;
    res_next.range_from   = keep_range ? v_first  : '0;
    res_next.range_to     = keep_range ? v_second : '0;
    res_next.has_length   = fin_ok && len_given;
    res_next.total_length = (fin_ok && len_given) ? v_acc : '0;
    res_next.unit_length  = fin_ok ? v_unit : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (v_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_adv) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/content_range_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// content_range_header_parser_unit: streaming Content-Range value parser
// Front classifier, short byte queue, and back parser with verdict stage.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle while the queue is not full; the queue
// fills only while the back parser holds a last byte. A byte marked last
// yields one verdict, registered in turn in the queue, the parser snapshot
// and the result register (the verdict compare sits in front of the result
// register). Further bytes keep flowing while a verdict waits in the result
// register; the parser only holds a second last byte while both verdict
// stage and result register are full and the result is stalled.
`default_nettype none

module content_range_header_parser_unit #(
  parameter int QUEUE_DEPTH = crh_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire crh_pkg::in_item_t  item,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output crh_pkg::out_item_t      res
);
  import crh_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_not_empty;
  logic    q_pop;
  q_item_t q_wdata;
  q_item_t q_rdata;

  crh_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  crh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rdata     (q_rdata)
  );

  crh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_item    (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// ===== design/crh_checker.sv =====
// ----------------------------------------------------------------------------
// crh_checker: port-level checks for the Content-Range parser
// Watches the result channel for consistent verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module crh_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               res_valid,
  input wire logic               res_stall,
  input wire crh_pkg::out_item_t res
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // a rejected value reports nothing else
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.valid_res |-> !res.has_range && !res.has_length &&
      res.range_from == '0 && res.range_to == '0 && res.total_length == '0 &&
      res.unit_length == '0)
    else $error("invalid verdict carries field data");

  // accepted ranges are ordered and inside the length
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.valid_res && res.has_range |->
      res.range_from <= res.range_to &&
      (!res.has_length || res.range_to < res.total_length))
    else $error("accepted range out of order");

  // star fields read as zero, and a good value has a unit
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.valid_res |->
      (res.has_range || (res.range_from == '0 && res.range_to == '0)) &&
      (res.has_length || res.total_length == '0) && res.unit_length != '0)
    else $error("accepted verdict fields inconsistent");

  // no result right after reset
  assert property (@(posedge clk) !rst && $past(rst) |-> !res_valid)
    else $error("result present after reset");

endmodule

bind content_range_header_parser_unit crh_checker u_crh_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

`default_nettype wire

// ===== verif/content_range_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_range_checker: verdict predictor and result comparator
// Follows every accepted header byte with its own parser state, forms the
// expected verdict on each last byte and compares it, field by field, with
// the results that leave the parser in order.
// ----------------------------------------------------------------------------
module content_range_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  crh_pkg::in_item_t  item,
  input  logic               res_valid,
  input  logic               res_stall,
  input  crh_pkg::out_item_t res,
  output int                 fail_count,
  output int                 pending
);
  import crh_pkg::*;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    SCAN_LEAD,
    SCAN_UNIT,
    SCAN_FROM,
    SCAN_TO,
    SCAN_LEN
  } scan_phase_t;

  scan_phase_t          scan;
  bit                   err;
  bit [UNIT_WIDTH-1:0]  unit_cnt;
  bit [NUM_WIDTH-1:0]   acc;
  bit                   acc_ovf;
  bit [NUM_WIDTH-1:0]   from_pos;
  bit [NUM_WIDTH-1:0]   to_pos;
  bit                   ranged;
  bit                   has_digits;
  bit                   closed;
  bit                   starred;

  out_item_t verdicts[$];

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic bit is_token(logic [7:0] c);
    if (is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
      return 1'b1;
    case (c) inside
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
      8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function void open_field(scan_phase_t p);
    scan       = p;
    acc        = '0;
    acc_ovf    = 1'b0;
    has_digits = 1'b0;
    closed     = 1'b0;
    starred    = 1'b0;
  endfunction

  function void clear_header();
    err      = 1'b0;
    unit_cnt = '0;
    from_pos = '0;
    to_pos   = '0;
    ranged   = 1'b0;
    open_field(SCAN_LEAD);
  endfunction

  function bit number_ready();
    return has_digits && !acc_ovf;
  endfunction

  function void consume(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - CH_ZERO);
    case (scan)
      SCAN_LEAD: begin
        if (is_token(c)) begin
          unit_cnt = 8'd1;
          scan     = SCAN_UNIT;
        end else if (!is_blank(c)) begin
          err = 1'b1;
        end
      end
      SCAN_UNIT: begin
        if (is_token(c)) begin
          if (unit_cnt != 8'hFF) unit_cnt++;
        end else if (is_blank(c)) begin
          open_field(SCAN_FROM);
        end else begin
          err = 1'b1;
        end
      end
      default: begin
        if (is_blank(c)) begin
          if (has_digits || starred) closed = 1'b1;
        end else if (is_digit(c)) begin
          if (closed || starred) begin
            err = 1'b1;
          end else begin
            // saturate into the overflow flag rather than wrap
            if ({1'b0, acc} > (MAX_POS - d) / 10) acc_ovf = 1'b1;
            else acc = NUM_WIDTH'({1'b0, acc} * 10 + d);
            has_digits = 1'b1;
          end
        end else if (c == CH_STAR) begin
          if (scan != SCAN_TO && !has_digits && !starred) starred = 1'b1;
          else err = 1'b1;
        end else if (c == CH_DASH && scan == SCAN_FROM && number_ready()) begin
          from_pos = acc;
          open_field(SCAN_TO);
        end else if (c == CH_SLASH && scan == SCAN_FROM && starred) begin
          ranged = 1'b0;
          open_field(SCAN_LEN);
        end else if (c == CH_SLASH && scan == SCAN_TO && number_ready()) begin
          to_pos = acc;
          ranged = 1'b1;
          open_field(SCAN_LEN);
        end else begin
          err = 1'b1;
        end
      end
    endcase
  endfunction

  function out_item_t verdict();
    out_item_t v;
    bit        ok;
    bit        len_given;
    v         = '0;
    ok        = !err && scan == SCAN_LEN;
    len_given = 1'b0;
    if (ok) begin
      if (starred) len_given = 1'b0;
      else if (number_ready()) len_given = 1'b1;
      else ok = 1'b0;
    end
    if (ok && ranged && from_pos > to_pos) ok = 1'b0;
    if (ok && ranged && len_given && to_pos >= acc) ok = 1'b0;
    if (ok) begin
      v.valid_res    = 1'b1;
      v.has_range    = ranged;
      v.range_from   = ranged ? from_pos : '0;
      v.range_to     = ranged ? to_pos : '0;
      v.has_length   = len_given;
      v.total_length = len_given ? acc : '0;
      v.unit_length  = unit_cnt;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (rst) begin
      clear_header();
      verdicts.delete();
      fail_count = 0;
    end else begin
      if (item_valid && !item_stall) begin
        if (!err) consume(item.data_byte);
        if (item.last_byte) begin
          verdicts.push_back(verdict());
          clear_header();
        end
      end
      if (res_valid && !res_stall) begin
        if (verdicts.size() == 0) begin
          $error("result with no verdict pending: %p", res);
          fail_count++;
        end else begin
          want = verdicts.pop_front();
          bad  = 1'b0;
          if (res.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, res.valid_res);
            bad = 1'b1;
          end
          if (res.has_range !== want.has_range) begin
            $error("has_range: expected %0d, got %0d", want.has_range, res.has_range);
            bad = 1'b1;
          end
          if (res.range_from !== want.range_from) begin
            $error("range_from: expected %0d, got %0d", want.range_from, res.range_from);
            bad = 1'b1;
          end
          if (res.range_to !== want.range_to) begin
            $error("range_to: expected %0d, got %0d", want.range_to, res.range_to);
            bad = 1'b1;
          end
          if (res.has_length !== want.has_length) begin
            $error("has_length: expected %0d, got %0d", want.has_length, res.has_length);
            bad = 1'b1;
          end
          if (res.total_length !== want.total_length) begin
            $error("total_length: expected %0d, got %0d",
                   want.total_length, res.total_length);
            bad = 1'b1;
          end
          if (res.unit_length !== want.unit_length) begin
            $error("unit_length: expected %0d, got %0d", want.unit_length, res.unit_length);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

// ===== verif/content_range_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_range_header_parser_unit_tb: stimulus and verdict for the parser
// Sends directed and random Content-Range values byte by byte, mostly well
// formed with random content, plus mangled values and noise, with random
// gaps on both channels. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module content_range_header_parser_unit_tb;
  import crh_pkg::*;

  localparam int ITEM_TARGET  = 1200;
  localparam int MIN_VERDICTS = 48;
  localparam int TAIL_VALUES  = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [62:0] MAX_POS = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_BACKTICK = 8'h60;

  localparam string TOKEN_SET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_|~";
  localparam string ODD_SET = " \t*-/059aZ~@:,;";

  typedef logic [7:0] text_t[$];

  logic      clk;
  logic      rst        = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item       = '0;
  logic      res_valid;
  logic      res_stall  = 1'b0;
  out_item_t res;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int bytes_sent  = 0;
  int values_sent = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;

  content_range_header_parser_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  content_range_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: stall in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !rst && $urandom_range(0, 6) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic text_t text_of(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
  endfunction

  function automatic text_t blanks(int max_n);
    text_t t;
    repeat ($urandom_range(0, max_n)) t.push_back(blank_char());
    return t;
  endfunction

  function automatic logic [7:0] token_char();
    if ($urandom_range(0, 63) == 0) return CH_BACKTICK;
    return TOKEN_SET[$urandom_range(0, TOKEN_SET.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return ODD_SET[$urandom_range(0, ODD_SET.len() - 1)];
  endfunction

  function automatic logic [62:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return 63'($urandom_range(0, 20));
      1: return 63'($urandom);
      2: return 63'({$urandom, $urandom});
      3: return MAX_POS - 63'($urandom_range(0, 3));
      default: return 63'($urandom_range(0, 1000));
    endcase
  endfunction

  // digits of a position, now and then one past the 63-bit limit or far beyond it
  function automatic text_t num_field(logic [62:0] v);
    text_t t;
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1)) return text_of("9223372036854775808");
      t.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(19, 21)) t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      return t;
    end
    t = text_of($sformatf("%0d", v));
    if ($urandom_range(0, 7) == 0) t.push_front(CH_ZERO);
    return t;
  endfunction

  function automatic text_t well_formed();
    text_t       t;
    logic [62:0] a, b, c, x;
    int          n;
    t = blanks(2);
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 8);
    repeat (n) t.push_back(token_char());
    t = {t, blank_char(), blanks(1)};
    a = rand_pos();
    b = rand_pos();
    c = rand_pos();
    // mostly ordered so that the range checks pass
    if ($urandom_range(0, 3) != 0) begin
      if (a > b) begin x = a; a = b; b = x; end
      if (b > c) begin x = b; b = c; c = x; end
      if (a > b) begin x = a; a = b; b = x; end
    end
    if ($urandom_range(0, 4) == 0) t = {t, CH_STAR};
    else t = {t, blanks(1), num_field(a), blanks(1), CH_DASH, blanks(1), num_field(b)};
    t = {t, blanks(1), CH_SLASH, blanks(1)};
    if ($urandom_range(0, 4) == 0) t = {t, CH_STAR};
    else t = {t, num_field(c)};
    return {t, blanks(1)};
  endfunction

  function automatic text_t mangled();
    text_t t;
    int    p;
    t = well_formed();
    p = $urandom_range(0, t.size() - 1);
    case ($urandom_range(0, 3))
      0: t[p] = rand_byte();
      1: t.insert(p, rand_byte());
      2: if (t.size() > 1) t.delete(p);
      default: while (t.size() > p + 1) t.pop_back();
    endcase
    return t;
  endfunction

  function automatic text_t noise();
    text_t t;
    repeat ($urandom_range(1, 8)) t.push_back(rand_byte());
    return t;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, last_byte: is_last};
    do @(posedge clk); while (item_stall);
    bytes_sent++;
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_byte(t[i], i == t.size() - 1);
    values_sent++;
  endtask

  task automatic send_string(input string s);
    send_text(text_of(s));
  endtask

  initial begin
    text_t long_unit;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_string("bytes 0-0/1");
    send_string(" \tb */*");
    send_string("b 9223372036854775806-9223372036854775806/9223372036854775807");
    send_string("b 1-9223372036854775808/*");
    send_string("b 5-3/9");
    send_string("b 0-9/9");
    send_string("b\t 1 -\t2 / 3 \t");
    send_string("!#$%&'*+-.^_|~09Az 7-7/*");
    send_string("b */5");
    send_string("b *-1/5");
    send_string("b 1 2-3/4");
    send_string("b 1-2/3/");
    send_string("b 1-2/");
    send_string("x");
    send_text({text_of("b"), 8'h80, text_of(" 1-2/3")});
    send_text({text_of("b 1-2/3"), 8'h00});
    // unit count saturates
    repeat (260) long_unit.push_back(CH_BACKTICK);
    send_text({long_unit, text_of(" 0-1/2")});

    while (bytes_sent < ITEM_TARGET || values_sent < MIN_VERDICTS) begin
      if (values_sent % 10 == 0) idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7)) inside
        0:       send_text(noise());
        1, 2:    send_text(mangled());
        default: send_text(well_formed());
      endcase
    end

    idle_on = 1'b0;
    repeat (TAIL_VALUES) send_text(well_formed());
    item_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== content_range_header_parser_unit.f =====
design/crh_pkg.sv
design/crh_front.sv
design/crh_queue.sv
design/crh_back.sv
design/content_range_header_parser_unit.sv
design/crh_checker.sv
verif/content_range_checker.sv
verif/content_range_header_parser_unit_tb.sv
